FILE: design/htdl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// htdl_pkg
// Shared constants, register codes and types of the hysteresis trigger
// with delay line.
// ----------------------------------------------------------------------------
package htdl_pkg;

  localparam int SampleBits   = 16;
  localparam int LevelBits    = 16;
  localparam int LineBits     = 3;
  localparam int TtlBits      = 8;
  localparam int DelayBits    = 12;
  localparam int StampBits    = 48;
  localparam int MaxDelay     = 4096;
  localparam int AddrBits     = $clog2(MaxDelay);
  localparam int CfgIndexBits = 2;
  localparam int CfgDataBits  = 16;
  localparam int InDataBits   = 16;
  localparam int OutDataBits  = 72;
  localparam int OutUserBits  = 2;

  localparam logic signed [LevelBits-1:0] TriggerReset = 16'sd10000;
  localparam logic signed [LevelBits-1:0] ReleaseReset = 16'sd5000;

  typedef enum logic [CfgIndexBits-1:0] {
    REG_TRIGGER_LEVEL = 2'd0,
    REG_RELEASE_LEVEL = 2'd1,
    REG_OUTPUT_LINE   = 2'd2,
    REG_DELAY_SAMPLES = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic                   we;
    cfg_reg_t               index;
    logic [CfgDataBits-1:0] data;
  } cfg_write_t;

  typedef struct packed {
    logic                 valid;
    logic                 on;
    logic [TtlBits-1:0]   ttl;
    logic [StampBits-1:0] stamp;
  } event_t;

endpackage
`default_nettype wire

FILE: design/htdl_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// htdl_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module htdl_ram #(
  parameter int Width = 16,
  parameter int Depth = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: design/htdl_trigger.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// htdl_trigger
// Schmitt trigger with selectable polarity and running sample timestamp.
// ----------------------------------------------------------------------------
module htdl_trigger import htdl_pkg::*; (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire cfg_write_t                   cfg,
  input  wire logic                         accept,
  input  wire logic signed [SampleBits-1:0] sample,
  output event_t                            evt
);

  logic signed [LevelBits-1:0] trigger_level;
  logic signed [LevelBits-1:0] release_level;
  logic [LineBits-1:0]         output_line;
  logic                        armed;
  logic [StampBits-1:0]        sample_count;
  logic                        rising;
  logic                        arm_hit;
  logic                        release_hit;

  always_comb begin
    rising      = trigger_level > release_level;
    arm_hit     = rising ? (sample >= trigger_level) : (sample <= trigger_level);
    release_hit = rising ? (sample <= release_level) : (sample >= release_level);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_level <= TriggerReset;
      release_level <= ReleaseReset;
      output_line   <= '0;
      armed         <= 1'b0;
      sample_count  <= '0;
    end else begin
      if (cfg.we) begin
        unique case (cfg.index)
          REG_TRIGGER_LEVEL: trigger_level <= $signed(cfg.data[LevelBits-1:0]);
          REG_RELEASE_LEVEL: release_level <= $signed(cfg.data[LevelBits-1:0]);
          REG_OUTPUT_LINE:   output_line   <= cfg.data[LineBits-1:0];
          REG_DELAY_SAMPLES: ;
          default: ;
        endcase
      end
      if (accept) begin
        armed        <= armed ? !release_hit : arm_hit;
        sample_count <= sample_count + 1'b1;
      end
    end
  end

  // event payload
  always_ff @(posedge clk) begin
    if (accept) begin
      evt.valid <= armed ? release_hit : arm_hit;
      evt.on    <= !armed && arm_hit;
      evt.ttl   <= (!armed && arm_hit) ? (TtlBits'(1) << output_line) : '0;
      evt.stamp <= sample_count;
    end
  end

endmodule
`default_nettype wire

FILE: design/htdl_delay.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// htdl_delay
// Programmable delay line on a circular RAM; a fill count stands in for
// clearing, so unwritten entries read as zero.
// ----------------------------------------------------------------------------
module htdl_delay import htdl_pkg::*; (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire cfg_write_t                   cfg,
  input  wire logic                         accept,
  input  wire logic signed [SampleBits-1:0] sample,
  output logic signed [SampleBits-1:0]      delayed_sample
);

  logic [DelayBits-1:0]  delay_samples;
  logic [AddrBits-1:0]   wp;
  logic [AddrBits-1:0]   fill;
  logic [AddrBits-1:0]   delay_eff;
  logic [AddrBits-1:0]   rd;
  logic                  use_mem;
  logic                  zero_delay;
  logic                  sel_mem;
  logic                  sel_zero;
  logic [SampleBits-1:0] sample_q;
  logic [SampleBits-1:0] rdata;

  always_comb begin
    if (int'(delay_samples) > MaxDelay - 1) begin
      delay_eff = AddrBits'(MaxDelay - 1);
    end else begin
      delay_eff = AddrBits'(delay_samples);
    end
    if (wp >= delay_eff) begin
      rd = wp - delay_eff;
    end else begin
      rd = wp + AddrBits'(MaxDelay) - delay_eff;
    end
    zero_delay = delay_eff == '0;
    use_mem    = !zero_delay && (fill >= delay_eff);
  end

  htdl_ram #(
    .Width (SampleBits),
    .Depth (MaxDelay)
  ) u_ram (
    .clk   (clk),
    .we    (accept),
    .waddr (wp),
    .wdata (sample),
    .re    (accept),
    .raddr (rd),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_samples <= '0;
      wp            <= '0;
      fill          <= '0;
    end else if (cfg.we && cfg.index == REG_DELAY_SAMPLES) begin
      delay_samples <= cfg.data[DelayBits-1:0];
      wp            <= '0;
      fill          <= '0;
    end else if (accept) begin
      wp <= (wp == AddrBits'(MaxDelay - 1)) ? '0 : wp + 1'b1;
      if (fill != AddrBits'(MaxDelay - 1)) begin
        fill <= fill + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sel_mem  <= use_mem;
      sel_zero <= zero_delay;
      sample_q <= sample;
    end
  end

  assign delayed_sample = sel_zero ? $signed(sample_q) :
                          sel_mem  ? $signed(rdata)    : '0;

endmodule
`default_nettype wire

FILE: design/hysteresis_trigger_with_delay_line.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hysteresis_trigger_with_delay_line
// Schmitt trigger on a sample stream with timestamped on/off events and a
// programmable delay line for the passed-through samples.
// ----------------------------------------------------------------------------
// usage
//   input stream: one signed sample per transfer on s_tdata
//   output stream: one result per input; m_tdata carries the delayed sample,
//   the ttl byte and the 48-bit sample timestamp, m_tuser the event flags
//   config: cfg_we writes cfg_data to register cfg_index (trigger level,
//   release level, output line, delay); writing the delay restarts the line
//   timing: result registered, valid in the cycle after the input transfer
//   throughput: one sample per cycle while m_tready stays high, set by one
//   read and one write of the delay RAM per sample
//   reset: levels 10000 / 5000, line 0, delay 0, trigger idle, timestamp 0;
//   at a nonzero delay the line reads as zero until refilled, no clearing
//   pass is needed, so inputs are taken in the first cycle after reset
//   stall: with m_tready low the result holds and s_tready drops; it rises
//   again in the cycle the result is taken
// ----------------------------------------------------------------------------
module hysteresis_trigger_with_delay_line import htdl_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    s_tvalid,
  output logic                         s_tready,
  input  wire logic [InDataBits-1:0]   s_tdata,   // sample_in
  output logic                         m_tvalid,
  input  wire logic                    m_tready,
  output logic [OutDataBits-1:0]       m_tdata,   // delayed_sample, ttl_byte, event_time
  output logic [OutUserBits-1:0]       m_tuser,   // event_valid, event_on
  input  wire logic                    cfg_we,
  input  wire logic [CfgIndexBits-1:0] cfg_index,
  input  wire logic [CfgDataBits-1:0]  cfg_data
);

  cfg_write_t                   cfg;
  event_t                       evt;
  logic                         accept;
  logic signed [SampleBits-1:0] sample;
  logic signed [SampleBits-1:0] delayed_sample;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_reg_t'(cfg_index);
  assign cfg.data  = cfg_data;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign sample   = $signed(s_tdata[SampleBits-1:0]);

  htdl_trigger u_trigger (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .accept (accept),
    .sample (sample),
    .evt    (evt)
  );

  htdl_delay u_delay (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .accept         (accept),
    .sample         (sample),
    .delayed_sample (delayed_sample)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= s_tvalid;
    end
  end

  assign m_tdata = {evt.stamp, evt.ttl, delayed_sample};
  assign m_tuser = {evt.on, evt.valid};

`ifndef SYNTHESIS
  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> m_tvalid)
    else $error("accepted sample produced no result");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output stage");

  a_on_is_event: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && evt.on |-> evt.valid && $onehot(evt.ttl))
    else $error("on-event without valid flag or one-hot ttl");

  a_off_ttl_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !evt.on |-> evt.ttl == '0)
    else $error("ttl byte set without on-event");

  a_stamp_steps: assert property (@(posedge clk) disable iff (rst)
    accept ##1 accept |=> evt.stamp == $past(evt.stamp) + 1'b1)
    else $error("timestamp did not advance by one");
`endif

endmodule
`default_nettype wire
